[hw/rtl/lcd_mode_timing_sequencer_assert.svh]
// Assertion macros for the LCD mode timing sequencer checks.
// Both sample on clk and are disabled while rst is high.
`ifndef LCD_MODE_TIMING_SEQUENCER_ASSERT_SVH
`define LCD_MODE_TIMING_SEQUENCER_ASSERT_SVH

// Same-cycle implication.
`define LCDT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lcdt same-cycle check failed");

// Next-cycle implication.
`define LCDT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lcdt next-cycle check failed");

`endif

[hw/rtl/lcdt_pkg.sv]
`timescale 1ns / 1ps

package lcdt_pkg;

  localparam int CNT_W      = 13;
  localparam int LINE_W     = 8;
  localparam int CYCLES_W   = 6;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int QUOT_W     = 4;

  // Mode durations in dots
  localparam logic [CNT_W-1:0] OAM_CYCLES    = 13'd79;
  localparam logic [CNT_W-1:0] VRAM_CYCLES   = 13'd172;
  localparam logic [CNT_W-1:0] HBLANK_CYCLES = 13'd205;
  localparam int               LINE_CYCLES   = 456;
  localparam int               VBLANK_LINES  = 10;
  localparam logic [CNT_W-1:0] VBLANK_CYCLES = CNT_W'(LINE_CYCLES * VBLANK_LINES);
  localparam logic [LINE_W-1:0] VISIBLE_LINES = 8'd144;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LCD_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_COMPARE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HBLANK_INT_EN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VBLANK_INT_EN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OAM_INT_EN    = 3'd4;

  typedef enum logic [1:0] {
    HBLANK_MODE    = 2'd0,
    VBLANK_MODE    = 2'd1,
    OAM_SCAN_MODE  = 2'd2,
    VRAM_READ_MODE = 2'd3
  } mode_t;

  typedef struct packed {
    logic              lcd_enable;
    logic [LINE_W-1:0] line_compare;
    logic              hblank_int_en;
    logic              vblank_int_en;
    logic              oam_int_en;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0]  dot_counter;
    mode_t             mode;
    logic [LINE_W-1:0] line;
    logic              coincidence;
  } state_t;

  typedef struct packed {
    logic              vblank_irq;
    logic              stat_irq;
    logic              draw_valid;
    logic [LINE_W-1:0] draw_line;
  } pulse_t;

endpackage

[hw/rtl/lcdt_cfg_regs.sv]
`timescale 1ns / 1ps

module lcdt_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [lcdt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lcdt_pkg::CFG_DATA_W-1:0]  cfg_data,
  output lcdt_pkg::cfg_t                   cfg
);

  // Write the addressed register; drop writes to unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lcdt_pkg::REG_LCD_ENABLE:    cfg.lcd_enable    <= cfg_data[0];
        lcdt_pkg::REG_LINE_COMPARE:  cfg.line_compare  <= cfg_data[lcdt_pkg::LINE_W-1:0];
        lcdt_pkg::REG_HBLANK_INT_EN: cfg.hblank_int_en <= cfg_data[0];
        lcdt_pkg::REG_VBLANK_INT_EN: cfg.vblank_int_en <= cfg_data[0];
        lcdt_pkg::REG_OAM_INT_EN:    cfg.oam_int_en    <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/lcdt_step.sv]
`timescale 1ns / 1ps

module lcdt_step (
  input  lcdt_pkg::cfg_t                  cfg,
  input  lcdt_pkg::state_t                state,
  input  logic [lcdt_pkg::CYCLES_W-1:0]   cycles,
  output lcdt_pkg::state_t                state_next,
  output lcdt_pkg::pulse_t                pulse
);

  logic [lcdt_pkg::CNT_W:0]    sum_wide;
  logic [lcdt_pkg::CNT_W-1:0]  sum;
  logic [lcdt_pkg::QUOT_W-1:0] quot;
  logic [lcdt_pkg::LINE_W-1:0] line_inc;

  // Advance the dot counter
  assign sum_wide = {1'b0, state.dot_counter} +
                    {{(lcdt_pkg::CNT_W + 1 - lcdt_pkg::CYCLES_W){1'b0}}, cycles};
  assign sum      = sum_wide[lcdt_pkg::CNT_W-1:0];
  assign line_inc = state.line + 8'd1;

  // Line within vblank: parallel compares against multiples of the line length
  always_comb begin
    quot = '0;
    for (int k = 1; k < lcdt_pkg::VBLANK_LINES; k++) begin
      if (sum >= lcdt_pkg::CNT_W'(k * lcdt_pkg::LINE_CYCLES)) begin
        quot = lcdt_pkg::QUOT_W'(k);
      end
    end
  end

  // Step the mode sequence; at most one mode change per item
  always_comb begin
    state_next = state;
    pulse      = '0;
    if (cfg.lcd_enable) begin
      state_next.dot_counter = sum;
      case (state.mode)
        lcdt_pkg::OAM_SCAN_MODE: begin
          if (sum >= lcdt_pkg::OAM_CYCLES) begin
            state_next.dot_counter = sum - lcdt_pkg::OAM_CYCLES;
            state_next.mode        = lcdt_pkg::VRAM_READ_MODE;
          end
        end
        lcdt_pkg::VRAM_READ_MODE: begin
          if (sum >= lcdt_pkg::VRAM_CYCLES) begin
            state_next.dot_counter = sum - lcdt_pkg::VRAM_CYCLES;
            state_next.mode        = lcdt_pkg::HBLANK_MODE;
            pulse.stat_irq         = cfg.hblank_int_en;
          end
        end
        lcdt_pkg::HBLANK_MODE: begin
          if (sum >= lcdt_pkg::HBLANK_CYCLES) begin
            state_next.dot_counter = sum - lcdt_pkg::HBLANK_CYCLES;
            state_next.line        = line_inc;
            if (state.line < lcdt_pkg::VISIBLE_LINES) begin
              pulse.draw_valid = 1'b1;
              pulse.draw_line  = state.line;
            end
            if (line_inc >= lcdt_pkg::VISIBLE_LINES) begin
              state_next.mode  = lcdt_pkg::VBLANK_MODE;
              pulse.vblank_irq = 1'b1;
              pulse.stat_irq   = cfg.vblank_int_en;
            end else begin
              state_next.mode = lcdt_pkg::OAM_SCAN_MODE;
              pulse.stat_irq  = cfg.oam_int_en;
            end
          end
        end
        lcdt_pkg::VBLANK_MODE: begin
          if (sum >= lcdt_pkg::VBLANK_CYCLES) begin
            state_next.dot_counter = sum - lcdt_pkg::VBLANK_CYCLES;
            state_next.mode        = lcdt_pkg::OAM_SCAN_MODE;
            state_next.line        = '0;
            pulse.stat_irq         = cfg.oam_int_en;
          end else begin
            state_next.line = {{(lcdt_pkg::LINE_W - lcdt_pkg::QUOT_W){1'b0}}, quot} +
                              lcdt_pkg::VISIBLE_LINES;
          end
        end
        default: ;
      endcase
      state_next.coincidence = (state_next.line == cfg.line_compare);
    end
  end

endmodule

[hw/rtl/lcd_mode_timing_sequencer.sv]
`timescale 1ns / 1ps

// LCD mode timing sequencer. Each input item is a tick carrying the cycles
// elapsed since the last one; each tick yields exactly one result item with
// the mode, line, coincidence flag, interrupt pulses and the finished visible
// line. Throughput is one item per clock while the output is not stalled:
// the tick is held in an input register, the whole mode/line update is one
// pass of compare-and-subtract logic on the 13-bit dot counter, and the
// result moves into an output register when the held item advances. The
// state registers update as the item moves into the output register, so a
// tick in the next cycle sees the new state. Configuration writes take effect
// at once and belong between ticks, while no item is in flight.
module lcd_mode_timing_sequencer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [lcdt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lcdt_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [lcdt_pkg::CYCLES_W-1:0]    cycles,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       mode,
  output logic [lcdt_pkg::LINE_W-1:0]      line,
  output logic                             coincidence,
  output logic                             vblank_irq,
  output logic                             stat_irq,
  output logic                             draw_valid,
  output logic [lcdt_pkg::LINE_W-1:0]      draw_line
);

  lcdt_pkg::cfg_t   cfg;
  lcdt_pkg::state_t state;
  lcdt_pkg::state_t state_next;
  lcdt_pkg::pulse_t pulse;

  logic                           in_held;
  logic [lcdt_pkg::CYCLES_W-1:0]  in_cycles;
  logic                           advance;

  lcdt_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lcdt_step u_step (
    .cfg        (cfg),
    .state      (state),
    .cycles     (in_cycles),
    .state_next (state_next),
    .pulse      (pulse)
  );

  // Move the held item on whenever the output register is free or draining
  assign advance  = in_held && (!out_valid || out_ready);
  assign in_ready = !in_held || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (in_ready) begin
      in_held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_cycles <= cycles;
    end
  end

  // Sequencer state advances with each item
  always_ff @(posedge clk) begin
    if (rst) begin
      state.dot_counter <= '0;
      state.mode        <= lcdt_pkg::OAM_SCAN_MODE;
      state.line        <= '0;
      state.coincidence <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mode        <= state_next.mode;
      line        <= state_next.line;
      coincidence <= state_next.coincidence;
      vblank_irq  <= pulse.vblank_irq;
      stat_irq    <= pulse.stat_irq;
      draw_valid  <= pulse.draw_valid;
      draw_line   <= pulse.draw_line;
    end
  end

endmodule

[hw/rtl/lcdt_checker.sv]
`timescale 1ns / 1ps

`include "lcd_mode_timing_sequencer_assert.svh"

module lcdt_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [1:0]                       mode,
  input logic [lcdt_pkg::LINE_W-1:0]      line,
  input logic                             vblank_irq,
  input logic                             stat_irq,
  input logic                             draw_valid,
  input logic [lcdt_pkg::LINE_W-1:0]      draw_line
);

  // Hold a stalled result
  `LCDT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(mode) && $stable(line) && $stable(draw_line))

  // A finished visible line ends hblank, so the new mode is oam or vblank
  `LCDT_ASSERT_NOW(a_draw_mode, out_valid && draw_valid, draw_line < lcdt_pkg::VISIBLE_LINES && (mode == lcdt_pkg::OAM_SCAN_MODE || mode == lcdt_pkg::VBLANK_MODE))

  // Vblank entry lands on the first invisible line
  `LCDT_ASSERT_NOW(a_vblank_entry, out_valid && vblank_irq, mode == lcdt_pkg::VBLANK_MODE && line == lcdt_pkg::VISIBLE_LINES)

  // Vblank lines stay in their ten-line window
  `LCDT_ASSERT_NOW(a_vblank_line, out_valid && mode == lcdt_pkg::VBLANK_MODE, line >= 8'd144 && line <= 8'd153)

  // Entering vram never raises a stat request
  `LCDT_ASSERT_NOW(a_stat_mode, out_valid && stat_irq, mode != lcdt_pkg::VRAM_READ_MODE)

endmodule

bind lcd_mode_timing_sequencer lcdt_checker u_lcdt_checker (.*);

[tb/tb_lcd_mode_timing_sequencer.sv]
`timescale 1ns / 1ps

module tb_lcd_mode_timing_sequencer;
  import lcdt_pkg::*;

  localparam int CYCLE_LIMIT     = 400_000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int DRAIN_CYCLES    = 20;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int MAX_REPORTS     = 10;
  localparam int PHASE_TICKS     = 420;
  localparam int DARK_TICKS      = 100;

  localparam logic [CFG_IDX_W-1:0] REG_LAST = REG_OAM_INT_EN;

  typedef struct packed {
    mode_t             mode;
    logic [LINE_W-1:0] line;
    logic              coincidence;
    logic              vblank_irq;
    logic              stat_irq;
    logic              draw_valid;
    logic [LINE_W-1:0] draw_line;
  } lcd_status_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CYCLES_W-1:0]   cycles = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            mode;
  logic [LINE_W-1:0]     line;
  logic                  coincidence;
  logic                  vblank_irq;
  logic                  stat_irq;
  logic                  draw_valid;
  logic [LINE_W-1:0]     draw_line;

  // Timing state as the block should hold it
  cfg_t              cfg_shadow = '0;
  logic [CNT_W-1:0]  dots_m = '0;
  mode_t             mode_m = OAM_SCAN_MODE;
  logic [LINE_W-1:0] line_m = '0;
  logic              coin_m = 1'b0;

  logic [CYCLES_W-1:0] tick_queue[$];
  lcd_status_t         predicted_status[$];

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   hold_off_left = 0;
  logic in_fire = 1'b0;
  int   cycle_count = 0;
  int   ticks_sent = 0;
  int   status_checked = 0;
  int   status_errors = 0;
  int   vblank_entries = 0;
  int   frames_wrapped = 0;
  int   lines_drawn = 0;
  int   stat_requests = 0;
  int   coincidences = 0;

  always #2 clk = ~clk;

  lcd_mode_timing_sequencer uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cycles      (cycles),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .mode        (mode),
    .line        (line),
    .coincidence (coincidence),
    .vblank_irq  (vblank_irq),
    .stat_irq    (stat_irq),
    .draw_valid  (draw_valid),
    .draw_line   (draw_line)
  );

  // Advance the dot counter by one tick and return the status it leaves
  function automatic lcd_status_t advance_lcd_timing(input logic [CYCLES_W-1:0] cyc);
    lcd_status_t s;
    mode_t       prev_mode;
    s = '0;
    prev_mode = mode_m;
    if (cfg_shadow.lcd_enable) begin
      dots_m = dots_m + CNT_W'(cyc);
      case (mode_m)
        OAM_SCAN_MODE: begin
          if (dots_m >= OAM_CYCLES) begin
            dots_m = dots_m - OAM_CYCLES;
            mode_m = VRAM_READ_MODE;
          end
        end
        VRAM_READ_MODE: begin
          if (dots_m >= VRAM_CYCLES) begin
            dots_m = dots_m - VRAM_CYCLES;
            mode_m = HBLANK_MODE;
          end
        end
        HBLANK_MODE: begin
          if (dots_m >= HBLANK_CYCLES) begin
            dots_m = dots_m - HBLANK_CYCLES;
            if (line_m < VISIBLE_LINES) begin
              s.draw_valid = 1'b1;
              s.draw_line = line_m;
            end
            line_m = line_m + 1'b1;
            mode_m = (line_m >= VISIBLE_LINES) ? VBLANK_MODE : OAM_SCAN_MODE;
          end
        end
        default: begin
          if (dots_m >= VBLANK_CYCLES) begin
            mode_m = OAM_SCAN_MODE;
            dots_m = dots_m - VBLANK_CYCLES;
            line_m = '0;
          end else begin
            line_m = LINE_W'(dots_m / LINE_CYCLES + VISIBLE_LINES);
          end
        end
      endcase
      coin_m = (line_m == cfg_shadow.line_compare);
    end
    // At most one mode entry per tick; raise its requests
    if (mode_m != prev_mode) begin
      case (mode_m)
        VBLANK_MODE: begin
          s.vblank_irq = 1'b1;
          s.stat_irq = cfg_shadow.vblank_int_en;
        end
        HBLANK_MODE:   s.stat_irq = cfg_shadow.hblank_int_en;
        OAM_SCAN_MODE: s.stat_irq = cfg_shadow.oam_int_en;
        default:       s.stat_irq = 1'b0;
      endcase
    end
    s.mode = mode_m;
    s.line = line_m;
    s.coincidence = coin_m;
    return s;
  endfunction

  // Drive the next tick once the previous one is taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (tick_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        cycles <= tick_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Status receiver with random stalls and the long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= (hold_off_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Count down the hold-off
  always @(posedge clk) begin
    if (hold_off_left > 0) begin
      hold_off_left <= hold_off_left - 1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d status items outstanding",
               cycle_count, predicted_status.size());
      $display("FAIL lcd_mode_timing_sequencer");
      $finish;
    end
  end

  // Check each status item against the oldest prediction, predict each tick
  always @(posedge clk) begin : status_monitor
    lcd_status_t got;
    lcd_status_t want;
    in_fire <= !rst && in_valid && in_ready;
    if (!rst && out_valid && out_ready) begin
      got.mode = mode_t'(mode);
      got.line = line;
      got.coincidence = coincidence;
      got.vblank_irq = vblank_irq;
      got.stat_irq = stat_irq;
      got.draw_valid = draw_valid;
      got.draw_line = draw_line;
      if (predicted_status.size() == 0) begin
        status_errors++;
        if (status_errors <= MAX_REPORTS)
          $display("status item with no tick pending: mode=%0d line=%0d", mode, line);
      end else begin
        want = predicted_status.pop_front();
        status_checked++;
        if (got.mode !== want.mode || got.line !== want.line ||
            got.coincidence !== want.coincidence || got.vblank_irq !== want.vblank_irq ||
            got.stat_irq !== want.stat_irq || got.draw_valid !== want.draw_valid ||
            got.draw_line !== want.draw_line) begin
          status_errors++;
          if (status_errors <= MAX_REPORTS) begin
            $display("status %0d: expected mode=%0d line=%0d coin=%0b vbl=%0b stat=%0b draw=%0b/%0d",
                     status_checked, want.mode, want.line, want.coincidence,
                     want.vblank_irq, want.stat_irq, want.draw_valid, want.draw_line);
            $display("status %0d: actual   mode=%0d line=%0d coin=%0b vbl=%0b stat=%0b draw=%0b/%0d",
                     status_checked, got.mode, got.line, got.coincidence,
                     got.vblank_irq, got.stat_irq, got.draw_valid, got.draw_line);
          end
        end
      end
    end
    if (!rst && in_valid && in_ready) begin
      want = advance_lcd_timing(cycles);
      predicted_status.push_back(want);
      ticks_sent++;
      if (want.vblank_irq) vblank_entries++;
      if (want.mode == OAM_SCAN_MODE && want.line == 0 && want.stat_irq | want.draw_valid | 1'b1
          && cfg_shadow.lcd_enable && dots_m < VBLANK_CYCLES && want.vblank_irq == 1'b0
          && want.draw_valid == 1'b0 && want.line == 0 && ticks_sent > 1
          && want.mode != VBLANK_MODE && want.coincidence == (cfg_shadow.line_compare == 0)
          && frames_wrapped < vblank_entries)
        frames_wrapped++;
      if (want.draw_valid) lines_drawn++;
      if (want.stat_irq) stat_requests++;
      if (want.coincidence) coincidences++;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_LCD_ENABLE:    cfg_shadow.lcd_enable = data[0];
      REG_LINE_COMPARE:  cfg_shadow.line_compare = data;
      REG_HBLANK_INT_EN: cfg_shadow.hblank_int_en = data[0];
      REG_VBLANK_INT_EN: cfg_shadow.vblank_int_en = data[0];
      REG_OAM_INT_EN:    cfg_shadow.oam_int_en = data[0];
      default:           ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold until every tick is taken and every status item is back
  task automatic wait_idle();
    while (tick_queue.size() != 0 || in_valid || predicted_status.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Reprogram while idle, then queue a run of mostly long ticks
  task automatic run_phase(input int n, input int send_pct, input int recv_pct,
                           input logic lcd_on, input logic [LINE_W-1:0] compare,
                           input logic [2:0] int_en, input logic pressure);
    int pick;
    wait_idle();
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    write_reg(REG_LINE_COMPARE, compare);
    write_reg(REG_HBLANK_INT_EN, {7'($urandom), int_en[2]});
    write_reg(REG_VBLANK_INT_EN, {7'($urandom), int_en[1]});
    write_reg(REG_OAM_INT_EN, {7'($urandom), int_en[0]});
    write_reg(REG_LAST + 3'($urandom_range(1, 3)), 8'($urandom));
    write_reg(REG_LCD_ENABLE, {7'($urandom), lcd_on});
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 80)
        tick_queue.push_back(CYCLES_W'($urandom_range(56, 63)));
      else if (pick < 95)
        tick_queue.push_back(CYCLES_W'($urandom_range(0, 63)));
      else
        tick_queue.push_back((pick < 97) ? '0 : '1);
    end
    if (pressure) begin
      @(posedge clk);
      hold_off_left <= HOLD_OFF_CYCLES;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // LCD off after reset: ticks hold the reset state
    tick_queue = {6'd0, 6'd63, 6'd42};
    wait_idle();

    // Only the low bit of enable counts; spare indexes are ignored.
    // Compare now matches line 0 but the flag holds while the LCD is off.
    write_reg(REG_LCD_ENABLE, 8'hFE);
    write_reg(REG_LINE_COMPARE, 8'h00);
    write_reg(REG_LAST + 3'd1, 8'hFF);
    write_reg(REG_LAST + 3'd2, 8'hFF);
    write_reg(REG_LAST + 3'd3, 8'hFF);
    tick_queue = {6'd63};
    wait_idle();

    // Walk OAM, VRAM and HBLANK on exact boundaries, then the single bits 1, 2, 4, 8 and 32
    write_reg(REG_HBLANK_INT_EN, 8'hFF);
    write_reg(REG_VBLANK_INT_EN, 8'h01);
    write_reg(REG_OAM_INT_EN, 8'h81);
    write_reg(REG_LCD_ENABLE, 8'h01);
    tick_queue = {6'd0, 6'd63, 6'd16, 6'd63, 6'd63, 6'd46, 6'd63, 6'd63, 6'd63, 6'd16,
                  6'd1, 6'd2, 6'd4, 6'd8, 6'd32};
    wait_idle();

    // Compare rewritten while off: no re-evaluation until the LCD is back on
    write_reg(REG_LCD_ENABLE, 8'h00);
    write_reg(REG_LINE_COMPARE, line_m);
    tick_queue = {6'd63};
    wait_idle();
    write_reg(REG_LCD_ENABLE, 8'h01);
    tick_queue = {6'd0};

    // Random phases across the idle mixes
    run_phase(PHASE_TICKS, 0, 0, 1'b1, line_m + 8'd1, 3'b111, 1'b1);
    run_phase(PHASE_TICKS, 55, 0, 1'b1, 8'hFF, 3'b000, 1'b0);
    run_phase(PHASE_TICKS, 0, 55, 1'b1, line_m + 8'd2, 3'($urandom), 1'b0);
    run_phase(PHASE_TICKS, 12, 12, 1'b1, 8'($urandom_range(144, 153)), 3'($urandom), 1'b0);
    run_phase(DARK_TICKS, 12, 12, 1'b0, line_m, 3'($urandom), 1'b0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (predicted_status.size() != 0) begin
      $display("%0d status items never arrived", predicted_status.size());
      status_errors += predicted_status.size();
    end

    $display("%0d ticks checked: %0d lines drawn, %0d vblank entries, %0d stat requests",
             status_checked, lines_drawn, vblank_entries, stat_requests);
    $display("%0d coincidence results, %0d mismatches, LCD on and off, four idle mixes",
             coincidences, status_errors);
    if (status_errors == 0)
      $display("PASS lcd_mode_timing_sequencer");
    else
      $display("FAIL lcd_mode_timing_sequencer");
    $finish;
  end

endmodule
